### src/fmbq_pkg.sv
// ----------------------------------------------------------------------------
// fmbq_pkg
// Shared types and constants for the front/middle/back queue: operation and
// status codes, stream word layout, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fmbq_pkg;

	localparam int OP_W      = 3;
	localparam int DATA_W    = 32;
	localparam int STAT_W    = 2;
	localparam int OCC_W     = 7;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT  = 3'd0,
		OP_PUSH_MIDDLE = 3'd1,
		OP_PUSH_BACK   = 3'd2,
		OP_POP_FRONT   = 3'd3,
		OP_POP_MIDDLE  = 3'd4,
		OP_POP_BACK    = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REBAL,
		ST_MOVE_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic cap_result;
		logic move_rd;
		logic move_wr;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic pop_ok;
		logic push_fb_ok;
		logic need_move;
	} dp_stat_t;

endpackage

### src/front_middle_back_queue_top.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue_top
// Queue of signed words with push and pop at the front, middle and back.
// ----------------------------------------------------------------------------
// Each input word carries one operation and passes through the execute step,
// the rebalance step, the move-write step when an entry has to cross between
// the halves, and the finish step that loads the output register. A middle
// push, a dropped push, a pop on an empty queue or an unused code goes from
// execute straight to finish. A new word is accepted only after finish, which
// waits while the previous result still sits in the output register. The move
// step comes from the single write port and registered read port of each
// half's ring memory: a crossing entry is read in the rebalance step and
// written in the move-write step. The output register lets the next word be
// accepted while a result still waits. No clearing pass runs after reset. At
// most CAPACITY words are held; a push beyond that is dropped with status full.
// ----------------------------------------------------------------------------
module front_middle_back_queue_top import fmbq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // op[2:0], push_value[34:3], zero pad
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // pop_value[31:0], status[33:32],
	                                       // occupancy[40:34], zero pad
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fmbq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fmbq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

endmodule

### src/fmbq_dp.sv
// ----------------------------------------------------------------------------
// fmbq_dp
// Datapath: front and back ring memories with their start pointers and
// counts, operand and result registers, and the output word register.
// ----------------------------------------------------------------------------
module fmbq_dp import fmbq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	logic [DATA_W-1:0] front_mem [CAPACITY];
	logic [DATA_W-1:0] back_mem  [CAPACITY];

	logic [IDX_W-1:0]  fstart_q, bstart_q, fstart_d, bstart_d;
	logic [CNT_W-1:0]  fcount_q, bcount_q, fcount_d, bcount_d;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] result_q, result_d;
	status_t           status_q, status_d;
	logic              pop_sel_q, pop_sel_d;
	logic              dir_q, dir_d;
	logic [DATA_W-1:0] f_rd_q, b_rd_q;
	logic [M_TDATA_W-1:0] out_q;

	logic              f_we, f_re, b_we, b_re;
	logic [IDX_W-1:0]  f_wa, f_ra, b_wa, b_ra;
	logic [DATA_W-1:0] f_wd, b_wd;

	logic [SUM_W-1:0]       total;
	logic [SUM_W+OCC_W-1:0] total_ext;
	logic                   full, empty, is_push, is_pop, is_push_fb;
	logic                   front_heavy, back_heavy;

	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] s,
	                                              input logic [CNT_W-1:0] k);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(s) + SUM_W'(k);
		if (sum >= CAP_SUM) begin
			sum = sum - CAP_SUM;
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] s);
		return (s == '0) ? LAST_IDX : s - 1'b1;
	endfunction

	assign total       = SUM_W'(fcount_q) + SUM_W'(bcount_q);
	assign total_ext   = {{OCC_W{1'b0}}, total};
	assign full        = total >= CAP_SUM;
	assign empty       = total == '0;
	assign is_push     = op_q == OP_PUSH_FRONT || op_q == OP_PUSH_MIDDLE || op_q == OP_PUSH_BACK;
	assign is_push_fb  = op_q == OP_PUSH_FRONT || op_q == OP_PUSH_BACK;
	assign is_pop      = op_q == OP_POP_FRONT || op_q == OP_POP_MIDDLE || op_q == OP_POP_BACK;
	assign front_heavy = fcount_q > bcount_q;
	assign back_heavy  = SUM_W'(bcount_q) > SUM_W'(fcount_q) + 1'b1;

	assign stat.pop_ok     = is_pop && !empty;
	assign stat.push_fb_ok = is_push_fb && !full;
	assign stat.need_move  = front_heavy || back_heavy;

	always_comb begin
		fstart_d  = fstart_q;
		bstart_d  = bstart_q;
		fcount_d  = fcount_q;
		bcount_d  = bcount_q;
		result_d  = result_q;
		status_d  = status_q;
		pop_sel_d = pop_sel_q;
		dir_d     = dir_q;
		f_we = 1'b0; f_wa = '0; f_wd = val_q; f_re = 1'b0; f_ra = '0;
		b_we = 1'b0; b_wa = '0; b_wd = val_q; b_re = 1'b0; b_ra = '0;

		if (cmd.exec) begin
			result_d = '0;
			status_d = STAT_DONE;
			if (is_push && full) begin
				status_d = STAT_FULL;
			end else if (is_pop && empty) begin
				result_d = '1;
				status_d = STAT_EMPTY;
			end else begin
				case (op_q)
					OP_PUSH_FRONT: begin
						fstart_d = ring_dec(fstart_q);
						f_we     = 1'b1;
						f_wa     = ring_dec(fstart_q);
						fcount_d = fcount_q + 1'b1;
					end
					OP_PUSH_MIDDLE: begin
						if (fcount_q < bcount_q) begin
							f_we     = 1'b1;
							f_wa     = ring_add(fstart_q, fcount_q);
							fcount_d = fcount_q + 1'b1;
						end else begin
							bstart_d = ring_dec(bstart_q);
							b_we     = 1'b1;
							b_wa     = ring_dec(bstart_q);
							bcount_d = bcount_q + 1'b1;
						end
					end
					OP_PUSH_BACK: begin
						b_we     = 1'b1;
						b_wa     = ring_add(bstart_q, bcount_q);
						bcount_d = bcount_q + 1'b1;
					end
					OP_POP_FRONT: begin
						if (fcount_q != '0) begin
							f_re      = 1'b1;
							f_ra      = fstart_q;
							fstart_d  = ring_add(fstart_q, CNT_W'(1));
							fcount_d  = fcount_q - 1'b1;
							pop_sel_d = 1'b0;
						end else begin
							b_re      = 1'b1;
							b_ra      = bstart_q;
							bstart_d  = ring_add(bstart_q, CNT_W'(1));
							bcount_d  = bcount_q - 1'b1;
							pop_sel_d = 1'b1;
						end
					end
					OP_POP_MIDDLE: begin
						if (fcount_q < bcount_q) begin
							b_re      = 1'b1;
							b_ra      = bstart_q;
							bstart_d  = ring_add(bstart_q, CNT_W'(1));
							bcount_d  = bcount_q - 1'b1;
							pop_sel_d = 1'b1;
						end else begin
							f_re      = 1'b1;
							f_ra      = ring_add(fstart_q, fcount_q - 1'b1);
							fcount_d  = fcount_q - 1'b1;
							pop_sel_d = 1'b0;
						end
					end
					OP_POP_BACK: begin
						if (bcount_q != '0) begin
							b_re      = 1'b1;
							b_ra      = ring_add(bstart_q, bcount_q - 1'b1);
							bcount_d  = bcount_q - 1'b1;
							pop_sel_d = 1'b1;
						end else begin
							f_re      = 1'b1;
							f_ra      = ring_add(fstart_q, fcount_q - 1'b1);
							fcount_d  = fcount_q - 1'b1;
							pop_sel_d = 1'b0;
						end
					end
					default: begin
						status_d = STAT_DONE;
					end
				endcase
			end
		end

		if (cmd.cap_result) begin
			result_d = pop_sel_q ? b_rd_q : f_rd_q;
		end

		// take one word off the heavier half; it lands in the other half next cycle
		if (cmd.move_rd) begin
			if (front_heavy) begin
				f_re     = 1'b1;
				f_ra     = ring_add(fstart_q, fcount_q - 1'b1);
				fcount_d = fcount_q - 1'b1;
				dir_d    = 1'b1;
			end else begin
				b_re     = 1'b1;
				b_ra     = bstart_q;
				bstart_d = ring_add(bstart_q, CNT_W'(1));
				bcount_d = bcount_q - 1'b1;
				dir_d    = 1'b0;
			end
		end

		if (cmd.move_wr) begin
			if (dir_q) begin
				bstart_d = ring_dec(bstart_q);
				b_we     = 1'b1;
				b_wa     = ring_dec(bstart_q);
				b_wd     = f_rd_q;
				bcount_d = bcount_q + 1'b1;
			end else begin
				f_we     = 1'b1;
				f_wa     = ring_add(fstart_q, fcount_q);
				f_wd     = b_rd_q;
				fcount_d = fcount_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstart_q <= '0;
			bstart_q <= '0;
			fcount_q <= '0;
			bcount_q <= '0;
		end else begin
			fstart_q <= fstart_d;
			bstart_q <= bstart_d;
			fcount_q <= fcount_d;
			bcount_q <= bcount_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= s_tdata[OP_W-1:0];
			val_q <= s_tdata[OP_W+DATA_W-1:OP_W];
		end
		result_q  <= result_d;
		status_q  <= status_d;
		pop_sel_q <= pop_sel_d;
		dir_q     <= dir_d;
		if (cmd.load_out) begin
			out_q <= {{(M_TDATA_W-OCC_W-STAT_W-DATA_W){1'b0}},
			          total_ext[OCC_W-1:0], status_q, result_q};
		end
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			front_mem[f_wa] <= f_wd;
		end
		if (f_re) begin
			f_rd_q <= front_mem[f_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			back_mem[b_wa] <= b_wd;
		end
		if (b_re) begin
			b_rd_q <= back_mem[b_ra];
		end
	end

	assign m_tdata = out_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total <= CAP_SUM)
		else $error("queue holds more than CAPACITY words");

	a_balanced_at_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (SUM_W'(bcount_q) == SUM_W'(fcount_q) ||
		                  SUM_W'(bcount_q) == SUM_W'(fcount_q) + 1'b1))
		else $error("halves out of balance when result is issued");

	a_full_push_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_push && full) |=> (status_q == STAT_FULL && $stable(total)))
		else $error("push on full queue not dropped");

endmodule

### src/fmbq_ctrl.sv
// ----------------------------------------------------------------------------
// fmbq_ctrl
// Controller: sequences one operation through execute, rebalance and move
// steps, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module fmbq_ctrl import fmbq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   pend_pop_q, pend_pop_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pend_pop_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			pend_pop_q  <= pend_pop_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		pend_pop_d  = pend_pop_q;
		cmd         = '0;
		s_tready    = 1'b0;
		out_valid_d = out_valid_q && !m_tready;

		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec   = 1'b1;
				pend_pop_d = stat.pop_ok;
				if (stat.pop_ok || stat.push_fb_ok) begin
					state_d = ST_REBAL;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_REBAL: begin
				cmd.cap_result = pend_pop_q;
				if (stat.need_move) begin
					cmd.move_rd = 1'b1;
					state_d     = ST_MOVE_WR;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_MOVE_WR: begin
				cmd.move_wr = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

	a_exec_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> $past(s_tvalid && s_tready))
		else $error("execute step without an accepted word");

	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && !m_tready) |=> (state_q == ST_FINISH))
		else $error("result register overwritten while still held");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result word withdrawn before it was taken");

endmodule
